FILE: rtl/core/qrs_pkg.sv
// shared types and constants for the quadratic root solver
package qrs_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int TOL_W          = 16;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_ALL     = 3'd1,
    KIND_LINEAR  = 3'd2,
    KIND_TWO     = 3'd3,
    KIND_DOUBLE  = 3'd4,
    KIND_COMPLEX = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  an;
    logic  bn;
    logic  cn;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

endpackage

FILE: rtl/core/qrs_in_if.sv
// coefficient request channel
interface qrs_in_if #(parameter int W = qrs_pkg::WORD_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

FILE: rtl/core/qrs_out_if.sv
// root result channel
interface qrs_out_if #(parameter int W = qrs_pkg::WORD_WIDTH_DEF);
  logic                valid;
  logic                ready;
  qrs_pkg::kind_t      root_kind;
  logic signed [W-1:0] first_root;
  logic signed [W-1:0] second_root;
  logic [W-2:0]        imag_part;
  logic                saturated;

  modport source (output valid, output root_kind, output first_root, output second_root,
                  output imag_part, output saturated, input ready);
  modport sink   (input valid, input root_kind, input first_root, input second_root,
                  input imag_part, input saturated, output ready);
endinterface

FILE: rtl/core/qrs_disc.sv
// coefficient decode, discriminant and classification pipeline
module qrs_disc #(
  parameter int W = qrs_pkg::WORD_WIDTH_DEF,
  parameter int F = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic signed [W-1:0]       a_i,
  input  logic signed [W-1:0]       b_i,
  input  logic signed [W-1:0]       c_i,
  input  logic [qrs_pkg::TOL_W-1:0] tol,
  output logic                      out_v,
  output qrs_pkg::ctl_t             ctl_o,
  output logic [W:0]                am_o,
  output logic [W:0]                bm_o,
  output logic [W:0]                cm_o,
  output logic [2*W+2:0]            dm_o
);
  import qrs_pkg::*;

  localparam int MG = W + 1;
  localparam int LW = MG / 2;
  localparam int HW = MG - LW;
  localparam int PW = 2 * MG;
  localparam int DW = 2 * MG + 1;
  localparam int CW = (DW > TOL_W + F) ? DW : TOL_W + F;

  // the most negative word has magnitude 2^W
  function automatic logic [MG-1:0] mag(input logic signed [W-1:0] x);
    logic [W-1:0] u;
    u = x;
    if (!u[W-1]) begin
      mag = {1'b0, u};
    end else if (u == {1'b1, {(W-1){1'b0}}}) begin
      mag = {1'b1, {W{1'b0}}};
    end else begin
      mag = {1'b0, ~u + 1'b1};
    end
  endfunction

  // stage 0: sign and magnitude
  logic          v0_r, an0_r, bn0_r, cn0_r;
  logic [MG-1:0] am0_r, bm0_r, cm0_r;
  // stage 1: partial products
  logic            v1_r, an1_r, bn1_r, cn1_r, asm1_r, bsm1_r, csm1_r;
  logic [MG-1:0]   am1_r, bm1_r, cm1_r;
  logic [2*LW-1:0] bll1_r, acll1_r;
  logic [MG-1:0]   blh1_r, aclh1_r, achl1_r;
  logic [2*HW-1:0] bhh1_r, achh1_r;
  // stage 2: full products
  logic          v2_r, an2_r, bn2_r, cn2_r, asm2_r, bsm2_r, csm2_r;
  logic [MG-1:0] am2_r, bm2_r, cm2_r;
  logic [PW-1:0] bb2_r, ac2_r;
  // stage 3: discriminant magnitude
  logic          v3_r, an3_r, bn3_r, cn3_r, asm3_r, bsm3_r, csm3_r, dneg3_r;
  logic [MG-1:0] am3_r, bm3_r, cm3_r;
  logic [DW-1:0] dm3_r;
  // stage 4: class
  logic          v4_r;
  ctl_t          ctl4_r;
  logic [MG-1:0] am4_r, bm4_r, cm4_r;
  logic [DW-1:0] dm4_r;

  logic [DW-1:0] bbx, ac4, dm_nxt;
  logic          dneg_nxt;
  logic [CW-1:0] tq, dmx;
  kind_t         kind_nxt;

  always_comb begin
    bbx = DW'(bb2_r);
    ac4 = DW'(ac2_r) << 2;
    dneg_nxt = 1'b0;
    if (an2_r != cn2_r) begin
      dm_nxt = bbx + ac4;
    end else if (bbx >= ac4) begin
      dm_nxt = bbx - ac4;
    end else begin
      dm_nxt   = ac4 - bbx;
      dneg_nxt = 1'b1;
    end
  end

  always_comb begin
    tq  = CW'(tol) << F;
    dmx = CW'(dm3_r);
    if (asm3_r) begin
      if (bsm3_r) begin
        kind_nxt = csm3_r ? KIND_ALL : KIND_NONE;
      end else begin
        kind_nxt = KIND_LINEAR;
      end
    end else if (!dneg3_r && dmx > tq) begin
      kind_nxt = KIND_TWO;
    end else if (dmx <= tq) begin
      kind_nxt = KIND_DOUBLE;
    end else begin
      kind_nxt = KIND_COMPLEX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_v;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an0_r <= a_i[W-1];
      bn0_r <= b_i[W-1];
      cn0_r <= c_i[W-1];
      am0_r <= mag(a_i);
      bm0_r <= mag(b_i);
      cm0_r <= mag(c_i);

      {an1_r, bn1_r, cn1_r} <= {an0_r, bn0_r, cn0_r};
      {am1_r, bm1_r, cm1_r} <= {am0_r, bm0_r, cm0_r};
      asm1_r  <= am0_r <= MG'(tol);
      bsm1_r  <= bm0_r <= MG'(tol);
      csm1_r  <= cm0_r <= MG'(tol);
      bll1_r  <= bm0_r[LW-1:0] * bm0_r[LW-1:0];
      blh1_r  <= bm0_r[LW-1:0] * bm0_r[MG-1:LW];
      bhh1_r  <= bm0_r[MG-1:LW] * bm0_r[MG-1:LW];
      acll1_r <= am0_r[LW-1:0] * cm0_r[LW-1:0];
      aclh1_r <= am0_r[LW-1:0] * cm0_r[MG-1:LW];
      achl1_r <= am0_r[MG-1:LW] * cm0_r[LW-1:0];
      achh1_r <= am0_r[MG-1:LW] * cm0_r[MG-1:LW];

      {an2_r, bn2_r, cn2_r}    <= {an1_r, bn1_r, cn1_r};
      {asm2_r, bsm2_r, csm2_r} <= {asm1_r, bsm1_r, csm1_r};
      {am2_r, bm2_r, cm2_r}    <= {am1_r, bm1_r, cm1_r};
      bb2_r <= (PW'(bhh1_r) << (2 * LW)) + (PW'(blh1_r) << (LW + 1)) + PW'(bll1_r);
      ac2_r <= (PW'(achh1_r) << (2 * LW)) + ((PW'(aclh1_r) + PW'(achl1_r)) << LW)
               + PW'(acll1_r);

      {an3_r, bn3_r, cn3_r}    <= {an2_r, bn2_r, cn2_r};
      {asm3_r, bsm3_r, csm3_r} <= {asm2_r, bsm2_r, csm2_r};
      {am3_r, bm3_r, cm3_r}    <= {am2_r, bm2_r, cm2_r};
      dm3_r   <= dm_nxt;
      dneg3_r <= dneg_nxt;

      ctl4_r.kind <= kind_nxt;
      ctl4_r.an   <= an3_r;
      ctl4_r.bn   <= bn3_r;
      ctl4_r.cn   <= cn3_r;
      {am4_r, bm4_r, cm4_r} <= {am3_r, bm3_r, cm3_r};
      dm4_r <= dm3_r;
    end
  end

  assign out_v = v4_r;
  assign ctl_o = ctl4_r;
  assign am_o  = am4_r;
  assign bm_o  = bm4_r;
  assign cm_o  = cm4_r;
  assign dm_o  = dm4_r;

endmodule

FILE: rtl/core/qrs_sqrt.sv
// pipelined integer square root, one result bit per stage
module qrs_sqrt #(
  parameter int IW     = 2 * qrs_pkg::WORD_WIDTH_DEF + 3,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  logic [IW-1:0]         x_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  out_v,
  output logic [(IW+1)/2-1:0]   root_o,
  output logic [SIDE_W-1:0]     side_o
);
  localparam int OW = (IW + 1) / 2;
  localparam int XW = 2 * OW;
  localparam int RW = OW + 3;

  logic              v_r    [OW];
  logic [OW-1:0]     root_r [OW];
  logic [SIDE_W-1:0] side_r [OW];
  logic [XW-1:0]     x_r    [OW-1];
  logic [RW-1:0]     rem_r  [OW-1];

  genvar k;
  for (k = 0; k < OW; k++) begin : g_st
    logic              pv;
    logic [XW-1:0]     px;
    logic [RW-1:0]     prem;
    logic [OW-1:0]     proot;
    logic [SIDE_W-1:0] pside;
    logic [RW-1:0]     rem_sh, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv    = in_v;
      assign px    = XW'(x_i);
      assign prem  = '0;
      assign proot = '0;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign px    = x_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign pside = side_r[k-1];
    end

    // bring down the next bit pair, try root*4+1
    assign rem_sh = {prem[RW-3:0], px[XW-1 -: 2]};
    assign trial  = RW'({proot, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {proot[OW-2:0], ge};
        side_r[k] <= pside;
      end
    end

    if (k < OW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k]   <= px << 2;
          rem_r[k] <= ge ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  assign out_v  = v_r[OW-1];
  assign root_o = root_r[OW-1];
  assign side_o = side_r[OW-1];

endmodule

FILE: rtl/core/qrs_div.sv
// pipelined rounding divider: floor((2*mag*2^F + den) / (2*den)) with overflow flag
module qrs_div #(
  parameter int W      = qrs_pkg::WORD_WIDTH_DEF,
  parameter int F      = qrs_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [W+1:0]      mag_i,
  input  logic [W+1:0]      den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              out_v,
  output logic [W:0]        q_o,
  output logic              ovf_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int MW  = W + 2;
  localparam int NW  = MW + F + 2;
  localparam int QB  = W + 1;
  localparam int HIW = NW - QB;
  localparam int DDW = W + 3;
  localparam int RW  = W + 4;
  localparam int CW  = (HIW > DDW) ? HIW : DDW;

  // numerator build
  logic              va_r;
  logic [NW-1:0]     na_r;
  logic [DDW-1:0]    da_r;
  logic [SIDE_W-1:0] sa_r;
  // overflow check on the high part
  logic              vb_r, ovfb_r;
  logic [RW-1:0]     remb_r;
  logic [QB-1:0]     lowb_r;
  logic [DDW-1:0]    db_r;
  logic [SIDE_W-1:0] sb_r;
  logic [HIW-1:0]    hi;
  logic              ovf_nxt;

  assign hi      = na_r[NW-1:QB];
  assign ovf_nxt = CW'(hi) >= CW'(da_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_v;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r   <= (NW'(mag_i) << (F + 1)) + NW'(den_i);
      da_r   <= {den_i, 1'b0};
      sa_r   <= side_i;
      ovfb_r <= ovf_nxt;
      remb_r <= ovf_nxt ? '0 : RW'(hi);
      lowb_r <= na_r[QB-1:0];
      db_r   <= da_r;
      sb_r   <= sa_r;
    end
  end

  logic              v_r    [QB];
  logic [QB-1:0]     q_r    [QB];
  logic              ovf_r  [QB];
  logic [SIDE_W-1:0] side_r [QB];
  logic [RW-1:0]     rem_r  [QB-1];
  logic [QB-1:0]     low_r  [QB-1];
  logic [DDW-1:0]    d_r    [QB-1];

  genvar k;
  for (k = 0; k < QB; k++) begin : g_st
    logic              pv, povf;
    logic [RW-1:0]     prem, rem_sh;
    logic [QB-1:0]     plow, pq;
    logic [DDW-1:0]    pd;
    logic [SIDE_W-1:0] pside;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv    = vb_r;
      assign povf  = ovfb_r;
      assign prem  = remb_r;
      assign plow  = lowb_r;
      assign pq    = '0;
      assign pd    = db_r;
      assign pside = sb_r;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign povf  = ovf_r[k-1];
      assign prem  = rem_r[k-1];
      assign plow  = low_r[k-1];
      assign pq    = q_r[k-1];
      assign pd    = d_r[k-1];
      assign pside = side_r[k-1];
    end

    assign rem_sh = {prem[RW-2:0], plow[QB-1]};
    assign ge     = rem_sh >= RW'(pd);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]    <= {pq[QB-2:0], ge};
        ovf_r[k]  <= povf;
        side_r[k] <= pside;
      end
    end

    if (k < QB - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (rem_sh - RW'(pd)) : rem_sh;
          low_r[k] <= plow << 1;
          d_r[k]   <= pd;
        end
      end
    end
  end

  assign out_v  = v_r[QB-1];
  assign q_o    = q_r[QB-1];
  assign ovf_o  = ovf_r[QB-1];
  assign side_o = side_r[QB-1];

endmodule

FILE: rtl/core/quadratic_root_solver_top.sv
// throughput: one request per cycle while the skid entry is empty;
// the square root and the dividers take one bit per stage
// a two-entry output buffer lets the pipeline keep going while one result waits
// reset: synchronous active low, clears every valid bit and sets the tolerance register tol_r to 0
// no memory and no clearing pass after reset
module quadratic_root_solver_top #(
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = qrs_pkg::WORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  qrs_in_if.sink                    in_ch,
  qrs_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [qrs_pkg::TOL_W-1:0] cfg_wdata
);
  import qrs_pkg::*;

  localparam int W      = WORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int DW     = 2 * W + 3;
  localparam int OW     = (DW + 1) / 2;
  localparam int MW     = W + 2;
  localparam int QB     = W + 1;
  localparam int SIDE_W = CTL_W + 3 * (W + 1);
  localparam logic [QB-1:0] HALF_Q  = QB'(1) << (W - 1);
  localparam logic [QB-1:0] LIM_POS = HALF_Q - 1'b1;

  logic [TOL_W-1:0] tol_r;
  logic             en;
  logic             sk_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  assign en          = !sk_v_r;
  assign in_ch.ready = en;

  // discriminant front end
  logic          ds_v;
  ctl_t          ds_ctl;
  logic [W:0]    ds_am, ds_bm, ds_cm;
  logic [DW-1:0] ds_dm;

  qrs_disc #(.W(W), .F(F)) u_disc (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_ch.valid),
    .a_i   (in_ch.coef_a),
    .b_i   (in_ch.coef_b),
    .c_i   (in_ch.coef_c),
    .tol   (tol_r),
    .out_v (ds_v),
    .ctl_o (ds_ctl),
    .am_o  (ds_am),
    .bm_o  (ds_bm),
    .cm_o  (ds_cm),
    .dm_o  (ds_dm)
  );

  // square root of the discriminant magnitude
  logic              sq_v;
  logic [OW-1:0]     sq_root;
  logic [SIDE_W-1:0] sq_side;
  ctl_t              sq_ctl;
  logic [W:0]        sq_am, sq_bm, sq_cm;

  qrs_sqrt #(.IW(DW), .SIDE_W(SIDE_W)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (ds_v),
    .x_i    (ds_dm),
    .side_i ({ds_ctl, ds_am, ds_bm, ds_cm}),
    .out_v  (sq_v),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign {sq_ctl, sq_am, sq_bm, sq_cm} = sq_side;

  // numerator and divisor selection per class
  logic          nb, ge_bs;
  logic [MW-1:0] bmx, sx, sum_bs, dif_bs, m1, m2;
  logic          sn1, sn2;
  logic [MW-1:0] mag1_nxt, mag2_nxt, magi_nxt;
  logic [W+1:0]  den_nxt;
  logic          neg1_nxt, neg2_nxt;

  logic          p_v_r;
  kind_t         p_kind_r;
  logic          p_neg1_r, p_neg2_r;
  logic [MW-1:0] p_mag1_r, p_mag2_r, p_magi_r;
  logic [W+1:0]  p_den_r;

  always_comb begin
    nb     = !sq_ctl.bn && (sq_bm != '0);
    bmx    = MW'(sq_bm);
    sx     = MW'(sq_root);
    sum_bs = bmx + sx;
    ge_bs  = bmx >= sx;
    dif_bs = ge_bs ? (bmx - sx) : (sx - bmx);
    // -b + s and -b - s as sign and magnitude
    m1  = nb ? dif_bs : sum_bs;
    sn1 = nb ? ge_bs : 1'b0;
    m2  = nb ? sum_bs : dif_bs;
    sn2 = nb ? 1'b1 : !ge_bs;

    mag1_nxt = '0;
    mag2_nxt = '0;
    magi_nxt = '0;
    den_nxt  = {sq_am, 1'b0};
    neg1_nxt = 1'b0;
    neg2_nxt = 1'b0;
    case (sq_ctl.kind)
      KIND_LINEAR: begin
        mag1_nxt = MW'(sq_cm);
        den_nxt  = {1'b0, sq_bm};
        neg1_nxt = (sq_cm != '0) && (sq_ctl.cn == sq_ctl.bn);
      end
      KIND_TWO: begin
        mag1_nxt = m1;
        mag2_nxt = m2;
        neg1_nxt = (m1 != '0) && (sn1 != sq_ctl.an);
        neg2_nxt = (m2 != '0) && (sn2 != sq_ctl.an);
      end
      KIND_DOUBLE, KIND_COMPLEX: begin
        mag1_nxt = bmx;
        magi_nxt = sx;
        neg1_nxt = (sq_bm != '0) && (sq_ctl.bn == sq_ctl.an);
      end
      default: begin
        mag1_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_kind_r <= sq_ctl.kind;
      p_neg1_r <= neg1_nxt;
      p_neg2_r <= neg2_nxt;
      p_mag1_r <= mag1_nxt;
      p_mag2_r <= mag2_nxt;
      p_magi_r <= magi_nxt;
      p_den_r  <= den_nxt;
    end
  end

  // three dividers in lockstep
  logic          d1_v, d2_v, d3_v;
  logic [QB-1:0] q1, q2, qi;
  logic          ovf1, ovf2, ovfi;
  logic          d1_neg, d2_neg;
  kind_t         d3_kind;

  qrs_div #(.W(W), .F(F), .SIDE_W(1)) u_div_first (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (p_v_r),
    .mag_i  (p_mag1_r),
    .den_i  (p_den_r),
    .side_i (p_neg1_r),
    .out_v  (d1_v),
    .q_o    (q1),
    .ovf_o  (ovf1),
    .side_o (d1_neg)
  );

  qrs_div #(.W(W), .F(F), .SIDE_W(1)) u_div_second (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (p_v_r),
    .mag_i  (p_mag2_r),
    .den_i  (p_den_r),
    .side_i (p_neg2_r),
    .out_v  (d2_v),
    .q_o    (q2),
    .ovf_o  (ovf2),
    .side_o (d2_neg)
  );

  qrs_div #(.W(W), .F(F), .SIDE_W($bits(kind_t))) u_div_imag (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (p_v_r),
    .mag_i  (p_magi_r),
    .den_i  (p_den_r),
    .side_i (p_kind_r),
    .out_v  (d3_v),
    .q_o    (qi),
    .ovf_o  (ovfi),
    .side_o (d3_kind)
  );

  // clip to range
  logic [QB-1:0] lim1, lim2;
  logic          sat1, sat2, sati, u1_nxt, u2_nxt, ui_nxt;

  logic          f_v_r, f_u1_r, f_u2_r, f_ui_r, f_neg1_r, f_neg2_r, f_sat_r;
  kind_t         f_kind_r;
  logic [W-1:0]  f_c1_r, f_c2_r;
  logic [W-2:0]  f_ci_r;

  always_comb begin
    lim1   = d1_neg ? HALF_Q : LIM_POS;
    lim2   = d2_neg ? HALF_Q : LIM_POS;
    sat1   = ovf1 || (q1 > lim1);
    sat2   = ovf2 || (q2 > lim2);
    sati   = ovfi || (qi > LIM_POS);
    u1_nxt = (d3_kind == KIND_LINEAR) || (d3_kind == KIND_TWO)
             || (d3_kind == KIND_DOUBLE) || (d3_kind == KIND_COMPLEX);
    u2_nxt = d3_kind == KIND_TWO;
    ui_nxt = d3_kind == KIND_COMPLEX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_kind_r <= d3_kind;
      f_u1_r   <= u1_nxt;
      f_u2_r   <= u2_nxt;
      f_ui_r   <= ui_nxt;
      f_neg1_r <= d1_neg;
      f_neg2_r <= d2_neg;
      f_c1_r   <= sat1 ? lim1[W-1:0] : q1[W-1:0];
      f_c2_r   <= sat2 ? lim2[W-1:0] : q2[W-1:0];
      f_ci_r   <= sati ? LIM_POS[W-2:0] : qi[W-2:0];
      f_sat_r  <= (u1_nxt && sat1) || (u2_nxt && sat2) || (ui_nxt && sati);
    end
  end

  // snap near-zero roots other than a linear root, apply sign, blank unused fields
  logic [W-1:0] s1, s2, r1_nxt, r2_nxt;
  logic [W-2:0] im_nxt;
  logic         snap1;

  always_comb begin
    snap1  = (f_kind_r != KIND_LINEAR) && (f_c1_r <= W'(tol_r));
    s1     = snap1 ? '0 : f_c1_r;
    s2     = (f_c2_r <= W'(tol_r)) ? '0 : f_c2_r;
    r1_nxt = f_u1_r ? (f_neg1_r ? (~s1 + 1'b1) : s1) : '0;
    r2_nxt = f_u2_r ? (f_neg2_r ? (~s2 + 1'b1) : s2) : '0;
    im_nxt = f_ui_r ? f_ci_r : '0;
  end

  // output register with skid entry
  logic         o_v_r, o_sat_r, sk_sat_r, fire_up, take;
  kind_t        o_kind_r, sk_kind_r;
  logic [W-1:0] o_r1_r, o_r2_r, sk_r1_r, sk_r2_r;
  logic [W-2:0] o_im_r, sk_im_r;

  assign fire_up = f_v_r && en;
  assign take    = out_ch.ready || !o_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r  <= 1'b0;
      sk_v_r <= 1'b0;
    end else if (take) begin
      if (sk_v_r) begin
        o_v_r  <= 1'b1;
        sk_v_r <= 1'b0;
      end else begin
        o_v_r <= fire_up;
      end
    end else if (fire_up) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (sk_v_r) begin
        o_kind_r <= sk_kind_r;
        o_r1_r   <= sk_r1_r;
        o_r2_r   <= sk_r2_r;
        o_im_r   <= sk_im_r;
        o_sat_r  <= sk_sat_r;
      end else begin
        o_kind_r <= f_kind_r;
        o_r1_r   <= r1_nxt;
        o_r2_r   <= r2_nxt;
        o_im_r   <= im_nxt;
        o_sat_r  <= f_sat_r;
      end
    end else if (fire_up) begin
      sk_kind_r <= f_kind_r;
      sk_r1_r   <= r1_nxt;
      sk_r2_r   <= r2_nxt;
      sk_im_r   <= im_nxt;
      sk_sat_r  <= f_sat_r;
    end
  end

  assign out_ch.valid       = o_v_r;
  assign out_ch.root_kind   = o_kind_r;
  assign out_ch.first_root  = o_r1_r;
  assign out_ch.second_root = o_r2_r;
  assign out_ch.imag_part   = o_im_r;
  assign out_ch.saturated   = o_sat_r;

`ifndef ASSERT_OFF
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (d1_v == d2_v) && (d2_v == d3_v))
    else $error("divider lanes out of step");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> o_v_r)
    else $error("skid entry held while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(o_v_r && !out_ch.ready && f_v_r))
    else $error("skid entry filled without a stalled result");

  a_trivial_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && ((o_kind_r == KIND_NONE) || (o_kind_r == KIND_ALL))
    |-> (o_r1_r == '0) && (o_r2_r == '0) && (o_im_r == '0) && !o_sat_r)
    else $error("root fields set for a class without roots");
`endif

endmodule

FILE: sim/quadratic_root_solver_top_test.sv
// self-checking testbench for the quadratic root solver: directed table, then random streams
module quadratic_root_solver_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [30:0] im;
    logic        sat;
  } roots_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        typed;
    roots_t      res;
  } row_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  qrs_in_if  #(32) in_ch ();
  qrs_out_if #(32) out_ch ();

  quadratic_root_solver_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [63:0] tol_model = 0;
  roots_t      pending_roots[$];
  int          fails = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;
  row_t        dir_rows[$];

  // sign and magnitude of a coefficient; the most negative word maps to 2^32
  function automatic logic [63:0] coef_mag(input logic [31:0] v);
    if (v == 32'h8000_0000) return 64'h1_0000_0000;
    return v[31] ? ({32'b0, ~v} + 64'd1) : {32'b0, v};
  endfunction

  function automatic logic [127:0] int_sqrt(input logic [127:0] num);
    logic [127:0] res, bitv;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv != 0 && bitv > num) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (num >= res + bitv) begin
        num = num - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] round_div(input logic [127:0] num, input logic [63:0] den,
                                            input logic [63:0] lim, inout logic sat);
    logic [127:0] q;
    q = ((num << 1) + den) / ({64'b0, den} << 1);
    if (q > lim) begin
      sat = 1'b1;
      return lim;
    end
    return q[63:0];
  endfunction

  function automatic logic [31:0] signed_root(input logic [127:0] mag, input logic [63:0] den,
                                              input logic neg, input logic snap, inout logic sat);
    logic [63:0] m;
    m = round_div(mag << 16, den, neg ? 64'h8000_0000 : 64'h7FFF_FFFF, sat);
    if (snap && m <= tol_model) m = 0;
    return neg ? 32'(-m) : m[31:0];
  endfunction

  function automatic roots_t solve_roots(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
    roots_t r;
    logic an, bn, cn, dneg, sat, n1, sn;
    logic [63:0] am, bm, cm, den;
    logic [127:0] bb, ac4, dm, tq, s, m;
    an = a[31]; bn = b[31]; cn = c[31];
    am = coef_mag(a); bm = coef_mag(b); cm = coef_mag(c);
    r = '0;
    sat = 1'b0;
    if (am <= tol_model) begin
      if (bm <= tol_model) r.kind = (cm > tol_model) ? KIND_NONE : KIND_ALL;
      else begin
        r.kind = KIND_LINEAR;
        r.r1 = signed_root(cm, bm, cm != 0 && cn == bn, 1'b0, sat);
      end
    end else begin
      bb = bm * bm;
      ac4 = (128'(am) * cm) << 2;
      tq = tol_model << 16;
      den = am << 1;
      dneg = 1'b0;
      if (an != cn) dm = bb + ac4;
      else if (bb >= ac4) dm = bb - ac4;
      else begin
        dneg = 1'b1;
        dm = ac4 - bb;
      end
      if (!dneg && dm > tq) begin
        r.kind = KIND_TWO;
        s = int_sqrt(dm);
        n1 = !bn && bm != 0;
        // -b + s
        if (!n1) begin sn = 1'b0; m = bm + s; end
        else if (bm >= s) begin sn = 1'b1; m = bm - s; end
        else begin sn = 1'b0; m = s - bm; end
        r.r1 = signed_root(m, den, m != 0 && (sn != an), 1'b1, sat);
        // -b - s
        if (n1) begin sn = 1'b1; m = bm + s; end
        else if (bm >= s) begin sn = 1'b0; m = bm - s; end
        else begin sn = 1'b1; m = s - bm; end
        r.r2 = signed_root(m, den, m != 0 && (sn != an), 1'b1, sat);
      end else begin
        r.r1 = signed_root(bm, den, bm != 0 && bn == an, 1'b1, sat);
        if (dm <= tq) r.kind = KIND_DOUBLE;
        else begin
          r.kind = KIND_COMPLEX;
          r.im = 31'(round_div(int_sqrt(dm) << 16, den, 64'h7FFF_FFFF, sat));
        end
      end
    end
    r.sat = sat;
    return r;
  endfunction

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    roots_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_roots.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        e = pending_roots.pop_front();
        if (out_ch.root_kind !== e.kind) begin
          $error("root_kind exp %0d got %0d", e.kind, out_ch.root_kind); fails++;
        end
        if (out_ch.first_root !== e.r1) begin
          $error("first_root exp %h got %h", e.r1, out_ch.first_root); fails++;
        end
        if (out_ch.second_root !== e.r2) begin
          $error("second_root exp %h got %h", e.r2, out_ch.second_root); fails++;
        end
        if (out_ch.imag_part !== e.im) begin
          $error("imag_part exp %h got %h", e.im, out_ch.imag_part); fails++;
        end
        if (out_ch.saturated !== e.sat) begin
          $error("saturated exp %b got %b", e.sat, out_ch.saturated); fails++;
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                              input logic typed, input roots_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.coef_a = a;
    in_ch.coef_b = b;
    in_ch.coef_c = c;
    do @(posedge clk); while (!in_ch.ready);
    pending_roots.push_back(typed ? res : solve_roots(a, b, c));
    @(negedge clk);
  endtask

  task automatic drain_and_set_tol(input logic [15:0] tol);
    in_ch.valid = 1'b0;
    while (pending_roots.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = tol;
    @(negedge clk);
    cfg_we = 1'b0;
    tol_model = tol;
  endtask

  function automatic row_t mk(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                              input logic typed, input kind_t k, input logic [31:0] r1,
                              input logic [31:0] r2, input logic [30:0] im, input logic sat);
    row_t r;
    r.a = a; r.b = b; r.c = c; r.typed = typed;
    r.res.kind = k; r.res.r1 = r1; r.res.r2 = r2; r.res.im = im; r.res.sat = sat;
    return r;
  endfunction

  task automatic random_request();
    logic [31:0] a, b, c, t;
    int sel;
    sel = $urandom_range(9);
    a = $urandom; b = $urandom; c = $urandom;
    case (sel)
      0, 1: ;
      2, 3, 4: begin
        a = $signed($urandom_range(65535 * 8)) - 65535 * 4;
        b = $signed($urandom_range(65535 * 16)) - 65535 * 8;
        c = $signed($urandom_range(65535 * 16)) - 65535 * 8;
      end
      5, 6: begin
        // exact double root: b = 2at, c = at^2
        a = $signed($urandom_range(2047)) - 1023;
        t = $signed($urandom_range(2047)) - 1023;
        b = 2 * a * t;
        c = a * t * t;
      end
      7: a = $urandom_range(2 * tol_model);
      8: begin
        a = $urandom_range(tol_model);
        b = $urandom_range(tol_model);
        if ($urandom_range(1)) c = $urandom_range(tol_model);
      end
      default: begin
        if ($urandom_range(1)) a = {$urandom_range(1), 31'b0};
        if ($urandom_range(1)) b = {$urandom_range(1), 31'b0};
        if ($urandom_range(1)) c = {$urandom_range(1), 31'b0};
      end
    endcase
    if ($urandom_range(3) == 0 && a[31]) a = -a;
    send_request(a, b, c, 1'b0, '0);
  endtask

  initial begin
    int idle_set[4][2];
    logic [15:0] tol_set[8];
    in_ch.valid = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;

    dir_rows.push_back(mk(0, 0, 0, 1, KIND_ALL, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 0, 32'h0001_0000, 1, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 0, 32'h8000_0000, 1, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 32'h0001_0000, 0, 1, KIND_LINEAR, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 1, 32'h7FFF_FFFF, 1, KIND_LINEAR, 32'h8000_0000, 0, 0, 1));
    dir_rows.push_back(mk(32'h0001_0000, 0, 32'hFFFF_0000, 1, KIND_TWO,
                          32'h0001_0000, 32'hFFFF_0000, 0, 0));
    dir_rows.push_back(mk(32'h0001_0000, 0, 32'h0001_0000, 1, KIND_COMPLEX,
                          0, 0, 31'h0001_0000, 0));
    dir_rows.push_back(mk(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000, 1, KIND_DOUBLE,
                          32'h0001_0000, 0, 0, 0));
    dir_rows.push_back(mk(0, 32'h0003_0000, 32'hFFFA_0000, 0, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 32'h7FFF_FFFF, 0, 0, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 0, 32'h7FFF_FFFF, 0, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 0, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h0000_8000, 32'h0001_8000, 32'hFFFF_0000, 0, KIND_NONE, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'hFFFE_0000, 32'h0004_0000, 32'hFFFE_0000, 0, KIND_NONE, 0, 0, 0, 0));

    idle_set = '{'{0, 0}, '{63, 0}, '{0, 63}, '{8, 8}};
    tol_set[0] = 16'hFFFF;
    tol_set[1] = $urandom_range(1, 64);
    tol_set[2] = $urandom;
    tol_set[3] = 0;
    tol_set[4] = $urandom_range(1, 4096);
    tol_set[5] = 16'hFFFF;
    tol_set[6] = $urandom;
    tol_set[7] = 16'h0001;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].typed,
                   dir_rows[i].res);

    for (int ph = 0; ph < 8; ph++) begin
      drain_and_set_tol(tol_set[ph]);
      send_idle_pct = idle_set[ph % 4][0];
      recv_stall_pct = idle_set[ph % 4][1];
      repeat (100) random_request();
    end

    in_ch.valid = 1'b0;
    while (pending_roots.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

FILE: quadratic_root_solver_top.f
rtl/core/qrs_pkg.sv
rtl/core/qrs_in_if.sv
rtl/core/qrs_out_if.sv
rtl/core/qrs_disc.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver_top.sv
sim/quadratic_root_solver_top_test.sv
